// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by greedy_register_allocator_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/gra_pkg.sv =====
// ----------------------------------------------------------------------------
// gra_pkg
// Types, codes and constants of the greedy register allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gra_pkg;

    localparam int NUM_MREGS = 16;
    localparam int MREG_W    = 4;
    localparam int VREG_W    = 10;
    localparam int STACK_W   = 16;
    localparam int PIDX_W    = 3;

    localparam logic [STACK_W-1:0]   SLOT_BYTES      = 16'd8;
    localparam logic [STACK_W-1:0]   STACK_MAX       = 16'hFFFF;
    localparam logic [NUM_MREGS-1:0] FREE_MASK_RESET = 16'hFC0B;

    typedef enum logic [1:0] {
        FUNC_FREE   = 2'd0,
        FUNC_DEFINE = 2'd1,
        FUNC_BIND   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OUT_NONE      = 3'd0,
        OUT_GIVEN     = 3'd1,
        OUT_SPILL     = 3'd2,
        OUT_PIN_SPILL = 3'd3,
        OUT_SKIPPED   = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_INDEX = 2'd2,
        ST_EXEC  = 2'd3
    } state_t;

    // Calling-convention register per parameter position:
    // rdi rsi rdx rcx r8 r9 r10 r11.
    function automatic logic [MREG_W-1:0] arg_reg(input logic [PIDX_W-1:0] pidx);
        logic [MREG_W-1:0] r;
        unique case (pidx)
            3'd0:    r = 4'd5;
            3'd1:    r = 4'd4;
            3'd2:    r = 4'd3;
            3'd3:    r = 4'd2;
            3'd4:    r = 4'd8;
            3'd5:    r = 4'd9;
            3'd6:    r = 4'd10;
            default: r = 4'd11;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/greedy_register_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_register_allocator_unit
// Greedy machine register allocator with stack spill over 16 registers.
//
//   channel   direction  handshake             word
//   item      in         start / busy          func vreg pin_valid pin_reg
//                                              param_index
//   result    out        done (strobe)         outcome reg_res slot_offset
//                                              stack_total stack_overflow
//   config    in         cfg_valid / cfg_ready initial_free_mask
//
// After reset the assigned-bit memory is cleared, one entry a cycle, over all
// NUM_VREGS entries; busy stays high meanwhile. Config writes are always taken.
// An item passes through accept, index and memory read, then execute; the
// registered read of the assigned-bit memory sets these steps.
// done pulses for one cycle in the cycle after execute; it cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module greedy_register_allocator_unit #(
    parameter int NUM_VREGS    = 1024,
    parameter int NUM_ARG_REGS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [9:0]  vreg,
    input  logic        pin_valid,
    input  logic [3:0]  pin_reg,
    input  logic [2:0]  param_index,
    output logic        done,
    output logic [2:0]  outcome,
    output logic [3:0]  reg_res,
    output logic [15:0] slot_offset,
    output logic [15:0] stack_total,
    output logic        stack_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] initial_free_mask
);

    localparam int IDX_W  = $clog2(NUM_VREGS);
    localparam int MREG_W = gra_pkg::MREG_W;
    localparam int NREG   = gra_pkg::NUM_MREGS;
    localparam int VW     = gra_pkg::VREG_W;
    localparam int SW     = gra_pkg::STACK_W;

    gra_pkg::state_t state_reg, state_next;

    logic                 accept;
    logic                 cfg_we;

    logic [1:0]           func_reg;
    logic [VW-1:0]        vreg_reg;
    logic                 pin_valid_reg;
    logic [MREG_W-1:0]    pin_reg_reg;
    logic [2:0]           pidx_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_comb;
    logic [IDX_W-1:0]     clr_cnt_reg;

    logic [NREG-1:0]      free_mask_reg, free_mask_next;
    logic [NREG-1:0]      owner_valid_reg, owner_valid_next;
    logic [VW-1:0]        owner_vreg_reg [NREG];
    logic [SW-1:0]        slot_reg, slot_next;
    logic                 overflow_reg, overflow_next;

    logic                 own_we;
    logic [MREG_W-1:0]    own_addr;
    logic                 assign_set;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    logic                 done_reg;
    logic [2:0]           outcome_reg, outcome_next;
    logic [MREG_W-1:0]    res_reg_reg, res_reg_next;
    logic [SW-1:0]        res_slot_reg, res_slot_next;

    logic [NREG-1:0]      hits;
    logic [MREG_W-1:0]    hit_idx;
    logic [MREG_W-1:0]    low_free;
    logic [MREG_W-1:0]    bind_reg;
    logic [SW:0]          slot_sum;
    logic [SW-1:0]        slot_taken;
    logic                 slot_ovf;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // ---------------------------------------------------------------- index
    generate
        if (NUM_VREGS < 1024)
        begin : g_wrap
            localparam int RECIP = 1024 / NUM_VREGS;
            localparam int Q_W   = $clog2(RECIP + 1);

            logic [Q_W-1:0] q_reg;
            logic [Q_W-1:0] q_next;
            logic [10:0]    prod;
            logic [10:0]    rem;

            assign q_next = Q_W'((20'(vreg) * 20'(RECIP)) >> 10);

            always_ff @(posedge clk)
            begin
                if (accept)
                begin
                    q_reg <= q_next;
                end
            end

            always_comb
            begin
                prod = 11'(11'(q_reg) * 11'(NUM_VREGS));
                rem  = {1'b0, vreg_reg} - prod;
                if (rem >= 11'(NUM_VREGS))
                begin
                    rem = rem - 11'(NUM_VREGS);
                end
                idx_comb = IDX_W'(rem);
            end
        end
        else
        begin : g_direct
            assign idx_comb = IDX_W'(vreg_reg);
        end
    endgenerate

    // ----------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gra_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            free_mask_reg   <= gra_pkg::FREE_MASK_RESET;
            owner_valid_reg <= '0;
            slot_reg        <= '0;
            overflow_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == gra_pkg::ST_EXEC);
            if (state_reg == gra_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                free_mask_reg <= initial_free_mask;
            end
            else
            begin
                free_mask_reg <= free_mask_next;
            end
            owner_valid_reg <= owner_valid_next;
            slot_reg        <= slot_next;
            overflow_reg    <= overflow_next;
        end
    end

    // ----------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func;
            vreg_reg      <= vreg;
            pin_valid_reg <= pin_valid;
            pin_reg_reg   <= pin_reg;
            pidx_reg      <= param_index;
        end
        if (state_reg == gra_pkg::ST_INDEX)
        begin
            idx_reg <= idx_comb;
        end
        if (own_we)
        begin
            owner_vreg_reg[own_addr] <= vreg_reg;
        end
        if (state_reg == gra_pkg::ST_EXEC)
        begin
            outcome_reg  <= outcome_next;
            res_reg_reg  <= res_reg_next;
            res_slot_reg <= res_slot_next;
        end
    end

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gra_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(NUM_VREGS - 1))
                begin
                    state_next = gra_pkg::ST_IDLE;
                end
            end
            gra_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = gra_pkg::ST_INDEX;
                end
            end
            gra_pkg::ST_INDEX: state_next = gra_pkg::ST_EXEC;
            gra_pkg::ST_EXEC:  state_next = gra_pkg::ST_IDLE;
            default:           state_next = gra_pkg::ST_CLEAR;
        endcase
    end

    // --------------------------------------------------------- state outputs
    always_comb
    begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = 1'b1;
        unique case (state_reg)
            gra_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 1'b0;
            end
            gra_pkg::ST_IDLE:  busy = 1'b0;
            gra_pkg::ST_INDEX: busy = 1'b1;
            gra_pkg::ST_EXEC:  ram_we = assign_set;
            default:           busy = 1'b1;
        endcase
    end

    // -------------------------------------------------------------- execute
    always_comb
    begin
        hits     = '0;
        hit_idx  = '0;
        low_free = '0;
        for (int r = 0; r < NREG; r++)
        begin
            hits[r] = owner_valid_reg[r] && (owner_vreg_reg[r] == vreg_reg);
        end
        for (int r = NREG - 1; r >= 0; r--)
        begin
            if (hits[r])
            begin
                hit_idx = MREG_W'(r);
            end
            if (free_mask_reg[r])
            begin
                low_free = MREG_W'(r);
            end
        end
    end

    assign bind_reg   = gra_pkg::arg_reg(pidx_reg);
    assign slot_sum   = {1'b0, slot_reg} + {1'b0, gra_pkg::SLOT_BYTES};
    assign slot_ovf   = slot_sum > {1'b0, gra_pkg::STACK_MAX};
    assign slot_taken = slot_ovf ? gra_pkg::STACK_MAX : slot_sum[SW-1:0];

    always_comb
    begin
        free_mask_next   = free_mask_reg;
        owner_valid_next = owner_valid_reg;
        slot_next        = slot_reg;
        overflow_next    = overflow_reg;
        own_we           = 1'b0;
        own_addr         = '0;
        assign_set       = 1'b0;
        outcome_next     = gra_pkg::OUT_NONE;
        res_reg_next     = '0;
        res_slot_next    = '0;

        if (state_reg == gra_pkg::ST_EXEC)
        begin
            unique case (gra_pkg::func_t'(func_reg))
                gra_pkg::FUNC_FREE:
                begin
                    if (hits != '0)
                    begin
                        free_mask_next[hit_idx]   = 1'b1;
                        owner_valid_next[hit_idx] = 1'b0;
                        outcome_next              = gra_pkg::OUT_GIVEN;
                        res_reg_next              = hit_idx;
                    end
                end
                gra_pkg::FUNC_DEFINE:
                begin
                    priority if (ram_rdata)
                    begin
                        outcome_next = gra_pkg::OUT_SKIPPED;
                    end
                    else if (pin_valid_reg && free_mask_reg[pin_reg_reg])
                    begin
                        own_we       = 1'b1;
                        own_addr     = pin_reg_reg;
                        assign_set   = 1'b1;
                        outcome_next = gra_pkg::OUT_GIVEN;
                        res_reg_next = pin_reg_reg;
                    end
                    else if (pin_valid_reg)
                    begin
                        slot_next     = slot_taken;
                        overflow_next = overflow_reg || slot_ovf;
                        res_slot_next = slot_reg;
                        outcome_next  = gra_pkg::OUT_PIN_SPILL;
                    end
                    else if (free_mask_reg != '0)
                    begin
                        own_we       = 1'b1;
                        own_addr     = low_free;
                        assign_set   = 1'b1;
                        outcome_next = gra_pkg::OUT_GIVEN;
                        res_reg_next = low_free;
                    end
                    else
                    begin
                        slot_next     = slot_taken;
                        overflow_next = overflow_reg || slot_ovf;
                        res_slot_next = slot_reg;
                        outcome_next  = gra_pkg::OUT_SPILL;
                    end
                end
                gra_pkg::FUNC_BIND:
                begin
                    if ({1'b0, pidx_reg} < 4'(NUM_ARG_REGS))
                    begin
                        own_we       = 1'b1;
                        own_addr     = bind_reg;
                        assign_set   = 1'b1;
                        outcome_next = gra_pkg::OUT_GIVEN;
                        res_reg_next = bind_reg;
                    end
                end
                default:
                begin
                    outcome_next = gra_pkg::OUT_NONE;
                end
            endcase

            // claim a machine register
            if (own_we)
            begin
                free_mask_next[own_addr]   = 1'b0;
                owner_valid_next[own_addr] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------ assigned bits
    gra_ram #(
        .WIDTH (1),
        .DEPTH (NUM_VREGS)
    ) u_assigned (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_comb),
        .rdata (ram_rdata)
    );

    // -------------------------------------------------------------- outputs
    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign reg_res        = res_reg_reg;
    assign slot_offset    = res_slot_reg;
    assign stack_total    = slot_reg;
    assign stack_overflow = overflow_reg;

    // ----------------------------------------------------------- assertions
    `ASSERT_PROP(a_done_after_exec, clk, rst_n,
        done |-> $past(state_reg == gra_pkg::ST_EXEC), "done without execute")
    `ASSERT_NEVER(a_done_while_busy, clk, rst_n, done && busy, "done while busy")
    `ASSERT_PROP(a_overflow_sticky, clk, rst_n,
        overflow_reg |=> overflow_reg, "overflow flag dropped")
    `ASSERT_PROP(a_stack_monotonic, clk, rst_n,
        state_reg != gra_pkg::ST_CLEAR |=> slot_reg >= $past(slot_reg),
        "stack total decreased")
    `ASSERT_NEVER(a_claim_outside_exec, clk, rst_n,
        own_we && (state_reg != gra_pkg::ST_EXEC), "owner write outside execute")

endmodule

// ===== rtl/gra_ram.sv =====
// ----------------------------------------------------------------------------
// gra_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
